/* rtl/nsdt_pkg.sv */
package nsdt_pkg;

   // Calendar limits
   localparam logic [5:0]  SEC_MAX   = 6'd59;
   localparam logic [5:0]  MIN_MAX   = 6'd59;
   localparam logic [4:0]  HOUR_MAX  = 5'd23;
   localparam logic [3:0]  MONTH_MAX = 4'd12;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [13:0] YEAR_MAX  = 14'd9999;

   // Year / 100 by reciprocal: floor(y * 5243 / 2^19) is exact for y below 43690
   localparam int          RECIP_W     = 13;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          PROD_W      = 14 + RECIP_W;
   localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [6:0]  CENTURY     = 7'd100;

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [5:0]  in_second;
      logic [5:0]  in_minute;
      logic [4:0]  in_hour;
      logic [4:0]  in_day;
      logic [3:0]  in_month;
      logic [13:0] in_year;
   } req_type;

   typedef struct packed {
      logic [5:0]  out_second;
      logic [5:0]  out_minute;
      logic [4:0]  out_hour;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [13:0] out_year;
      logic        day_rolled;
      logic        invalid;
   } rsp_type;

   // First stage result: item plus scaled year product
   typedef struct packed {
      req_type           item;
      logic [PROD_W-1:0] prod;
   } div_type;

   // Second stage result: item plus range and month-end flags
   typedef struct packed {
      req_type item;
      logic    bad;
      logic    day_last;
   } chk_type;

   // Length of month mo (1..12); codes outside that read as the last entry
   function automatic logic [4:0] month_days(logic [3:0] mo, logic leap);
      logic [3:0] idx;
      logic [4:0] len;
      idx = mo - 4'd1;
      if (idx > 4'd11) begin
         len = MONTH_LEN[11];
      end else begin
         len = MONTH_LEN[idx];
      end
      if (mo == MONTH_FEB && leap) begin
         len = 5'd29;
      end
      return len;
   endfunction

endpackage

/* rtl/next_second_date_time.sv */
// Gregorian date/time one-second increment.
// req_valid/req_ready/req_data carry a date and 24-hour time in; rsp_valid/
// rsp_ready/rsp_data return the moment one second later, with day_rolled set
// when midnight was crossed and invalid set when any input field is out of
// calendar range (then the input date and time are echoed unchanged).
// Throughput: one item per cycle unless stalled; three register stages
// (year scaling by the reciprocal of 100, leap year and range checks, field
// increment) each hold one item with its own valid bit.
// Stall: when rsp_ready is low, the output holds its result and stages fill
// behind it; req_ready drops only once all three stages hold an item, and no
// item is lost or repeated.
// Reset: synchronous, active high; empties all stages, no result is pending.
module next_second_date_time (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nsdt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nsdt_pkg::rsp_type rsp_data
);
   import nsdt_pkg::*;

   logic    div_valid;
   logic    div_ready;
   div_type div_data;
   logic    chk_valid;
   logic    chk_ready;
   chk_type chk_data;

   // Scale year
   nsdt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_data),
      .dn_valid (div_valid),
      .dn_ready (div_ready),
      .dn_data  (div_data)
   );

   // Check ranges and month end
   nsdt_check u_check (
      .clock    (clock),
      .reset    (reset),
      .up_valid (div_valid),
      .up_ready (div_ready),
      .up_data  (div_data),
      .dn_valid (chk_valid),
      .dn_ready (chk_ready),
      .dn_data  (chk_data)
   );

   // Advance by one second
   nsdt_adv u_adv (
      .clock    (clock),
      .reset    (reset),
      .up_valid (chk_valid),
      .up_ready (chk_ready),
      .up_data  (chk_data),
      .dn_valid (rsp_valid),
      .dn_ready (rsp_ready),
      .dn_data  (rsp_data)
   );

`ifndef SYNTH
   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("next_second_date_time: stalled while output drains");
   a_full_pipe_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && chk_valid && div_valid)
      else $error("next_second_date_time: input stalled with room inside");
   a_echo_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid |-> rsp_data.out_day == 5'd0 ||
         rsp_data.out_month == 4'd0 || rsp_data.out_month > MONTH_MAX ||
         rsp_data.out_second > SEC_MAX || rsp_data.out_minute > MIN_MAX ||
         rsp_data.out_hour > HOUR_MAX || rsp_data.out_year > YEAR_MAX ||
         rsp_data.out_day > 5'd28)
      else $error("next_second_date_time: invalid flag on in-range fields");
`endif

endmodule

/* rtl/nsdt_div.sv */
module nsdt_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  nsdt_pkg::req_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output nsdt_pkg::div_type dn_data
);
   import nsdt_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   // Scale the year by the reciprocal of 100
   always_comb begin
      data_in.item = up_data;
      data_in.prod = PROD_W'(up_data.in_year) * PROD_W'(RECIP_100);
   end

   assign up_ready = !valid_ff || dn_ready;

   // Advance the stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // Load data on transfer
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

`ifndef SYNTH
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !dn_ready |=> valid_ff && $stable(data_ff))
      else $error("nsdt_div: stalled stage changed");
   a_prod_match: assert property (@(posedge clock) disable iff (reset)
      up_valid && up_ready |=> data_ff.prod ==
         PROD_W'(data_ff.item.in_year) * PROD_W'(RECIP_100))
      else $error("nsdt_div: product mismatch");
`endif

endmodule

/* rtl/nsdt_check.sv */
module nsdt_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  nsdt_pkg::div_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output nsdt_pkg::chk_type dn_data
);
   import nsdt_pkg::*;

   logic              valid_ff;
   chk_type           data_ff;
   chk_type           data_in;
   logic [QUOT_W-1:0] quot;
   logic [13:0]       rem;
   logic              leap;
   logic [4:0]        mlen;
   req_type           it;

   // Finish year / 100, derive leap year, month length and range checks
   always_comb begin
      it   = up_data.item;
      quot = up_data.prod[PROD_W-1:RECIP_SHIFT];
      rem  = it.in_year - (14'(quot) * 14'(CENTURY));
      leap = ((it.in_year[1:0] == 2'd0) && (rem != 14'd0)) ||
             ((rem == 14'd0) && (quot[1:0] == 2'd0));
      mlen = month_days(it.in_month, leap);
      data_in.item     = it;
      data_in.day_last = (it.in_day == mlen);
      data_in.bad      = (it.in_second > SEC_MAX) || (it.in_minute > MIN_MAX) ||
                         (it.in_hour > HOUR_MAX) || (it.in_month == 4'd0) ||
                         (it.in_month > MONTH_MAX) || (it.in_year > YEAR_MAX) ||
                         (it.in_day == 5'd0) || (it.in_day > mlen);
   end

   assign up_ready = !valid_ff || dn_ready;

   // Advance the stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // Load data on transfer
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

`ifndef SYNTH
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !dn_ready |=> valid_ff && $stable(data_ff))
      else $error("nsdt_check: stalled stage changed");
   a_month_end_day: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.bad && data_ff.day_last |->
         data_ff.item.in_day >= 5'd28)
      else $error("nsdt_check: month end below day 28");
`endif

endmodule

/* rtl/nsdt_adv.sv */
module nsdt_adv (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  nsdt_pkg::chk_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output nsdt_pkg::rsp_type dn_data
);
   import nsdt_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;
   rsp_type data_in;
   req_type it;

   // Carry the one-second increment through the fields
   always_comb begin
      it = up_data.item;
      data_in.out_second = it.in_second;
      data_in.out_minute = it.in_minute;
      data_in.out_hour   = it.in_hour;
      data_in.out_day    = it.in_day;
      data_in.out_month  = it.in_month;
      data_in.out_year   = it.in_year;
      data_in.day_rolled = 1'b0;
      data_in.invalid    = up_data.bad;
      priority if (up_data.bad) begin
         // echo input
      end else if (it.in_second != SEC_MAX) begin
         data_in.out_second = it.in_second + 6'd1;
      end else if (it.in_minute != MIN_MAX) begin
         data_in.out_second = 6'd0;
         data_in.out_minute = it.in_minute + 6'd1;
      end else if (it.in_hour != HOUR_MAX) begin
         data_in.out_second = 6'd0;
         data_in.out_minute = 6'd0;
         data_in.out_hour   = it.in_hour + 5'd1;
      end else begin
         data_in.out_second = 6'd0;
         data_in.out_minute = 6'd0;
         data_in.out_hour   = 5'd0;
         data_in.day_rolled = 1'b1;
         priority if (!up_data.day_last) begin
            data_in.out_day = it.in_day + 5'd1;
         end else if (it.in_month != MONTH_MAX) begin
            data_in.out_day   = 5'd1;
            data_in.out_month = it.in_month + 4'd1;
         end else begin
            data_in.out_day   = 5'd1;
            data_in.out_month = 4'd1;
            data_in.out_year  = (it.in_year == YEAR_MAX) ? 14'd0 : it.in_year + 14'd1;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   // Advance the output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   // Load result on transfer
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

`ifndef SYNTH
   a_invalid_no_roll: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.invalid |-> !data_ff.day_rolled)
      else $error("nsdt_adv: invalid result marked rolled");
   a_roll_midnight: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.day_rolled |->
         data_ff.out_second == 6'd0 && data_ff.out_minute == 6'd0 &&
         data_ff.out_hour == 5'd0)
      else $error("nsdt_adv: day rolled away from midnight");
   a_roll_day_valid: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.day_rolled |-> data_ff.out_day != 5'd0 &&
         data_ff.out_month != 4'd0 && data_ff.out_month <= MONTH_MAX)
      else $error("nsdt_adv: rolled date out of range");
`endif

endmodule

/* sim/date_time_checker.sv */
module date_time_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  nsdt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  nsdt_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                waiting_count
);
   import nsdt_pkg::*;

   localparam int LAST_SECOND = 59;
   localparam int LAST_MINUTE = 59;
   localparam int LAST_HOUR   = 23;
   localparam int LAST_MONTH  = 12;
   localparam int LAST_YEAR   = 9999;

   // Moments one second later, in order of request transfer
   rsp_type moments_due[$];

   function automatic logic leap_year(logic [13:0] y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // Month must already lie in 1..12
   function automatic int days_of_month(logic [3:0] mo, logic [13:0] y);
      case (mo)
         4'd2: begin
            return leap_year(y) ? 29 : 28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   function automatic rsp_type next_moment(req_type t);
      rsp_type r;
      logic    bad;
      int      month_days;
      r.out_second = t.in_second;
      r.out_minute = t.in_minute;
      r.out_hour   = t.in_hour;
      r.out_day    = t.in_day;
      r.out_month  = t.in_month;
      r.out_year   = t.in_year;
      r.day_rolled = 1'b0;
      r.invalid    = 1'b0;
      bad = t.in_second > LAST_SECOND || t.in_minute > LAST_MINUTE ||
            t.in_hour > LAST_HOUR || t.in_month == 0 || t.in_month > LAST_MONTH ||
            t.in_year > LAST_YEAR || t.in_day == 0;
      month_days = bad ? 0 : days_of_month(t.in_month, t.in_year);
      if (!bad && t.in_day > month_days) begin
         bad = 1'b1;
      end
      // Echo the input on any out-of-range field
      if (bad) begin
         r.invalid = 1'b1;
      end else if (t.in_second != LAST_SECOND) begin
         r.out_second = t.in_second + 6'd1;
      end else if (t.in_minute != LAST_MINUTE) begin
         r.out_second = '0;
         r.out_minute = t.in_minute + 6'd1;
      end else if (t.in_hour != LAST_HOUR) begin
         r.out_second = '0;
         r.out_minute = '0;
         r.out_hour   = t.in_hour + 5'd1;
      end else begin
         // Midnight: advance the date
         r.out_second = '0;
         r.out_minute = '0;
         r.out_hour   = '0;
         r.day_rolled = 1'b1;
         if (t.in_day != month_days) begin
            r.out_day = t.in_day + 5'd1;
         end else if (t.in_month != LAST_MONTH) begin
            r.out_day   = 5'd1;
            r.out_month = t.in_month + 4'd1;
         end else begin
            r.out_day   = 5'd1;
            r.out_month = 4'd1;
            r.out_year  = (t.in_year == LAST_YEAR) ? 14'd0 : t.in_year + 14'd1;
         end
      end
      return r;
   endfunction

   function automatic int field_diff(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Match each result transfer with the oldest pending moment
   always @(posedge clock) begin
      rsp_type want;
      int      bad_fields;
      bad_fields = 0;
      if (reset) begin
         moments_due.delete();
         mismatch_count <= 0;
         waiting_count  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (moments_due.size() == 0) begin
               $error("result transfer with none pending: %p", rsp_data);
               bad_fields = 1;
            end else begin
               want = moments_due.pop_front();
               bad_fields += field_diff("out_second", want.out_second, rsp_data.out_second);
               bad_fields += field_diff("out_minute", want.out_minute, rsp_data.out_minute);
               bad_fields += field_diff("out_hour", want.out_hour, rsp_data.out_hour);
               bad_fields += field_diff("out_day", want.out_day, rsp_data.out_day);
               bad_fields += field_diff("out_month", want.out_month, rsp_data.out_month);
               bad_fields += field_diff("out_year", want.out_year, rsp_data.out_year);
               bad_fields += field_diff("day_rolled", want.day_rolled, rsp_data.day_rolled);
               bad_fields += field_diff("invalid", want.invalid, rsp_data.invalid);
            end
            mismatch_count <= mismatch_count + bad_fields;
         end
         if (req_valid && req_ready) begin
            moments_due.push_back(next_moment(req_data));
         end
         waiting_count <= moments_due.size();
      end
   end

endmodule

/* sim/testbench.sv */
module testbench;
   import nsdt_pkg::*;

   localparam int RANDOM_ITEMS  = 1450;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;

   // Years that stress the leap rules and the wrap
   localparam int SPECIAL_YEARS [10] = '{0, 4, 100, 400, 1900, 2000, 2024, 2100, 9996, 9999};

   typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_SPARSE} sink_mode_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   int            mismatch_count;
   int            waiting_count;
   int            burst_left    = 0;
   int            idle_cycles   = 0;
   int            sink_stretch  = 0;
   sink_mode_type sink_mode     = SINK_OPEN;

   always #5 clock = ~clock;

   next_second_date_time dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   date_time_checker date_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   function automatic req_type moment(int s, int mi, int h, int d, int mo, int y);
      req_type t;
      t.in_second = 6'(s);
      t.in_minute = 6'(mi);
      t.in_hour   = 5'(h);
      t.in_day    = 5'(d);
      t.in_month  = 4'(mo);
      t.in_year   = 14'(y);
      return t;
   endfunction

   // Mostly calendar-valid moments biased toward rollovers, some raw noise
   function automatic req_type random_moment();
      req_type t;
      if ($urandom_range(0, 9) == 0) begin
         t = moment($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            t = moment(59, 59, 23, 1, 1, 0);
         end else begin
            t = moment($urandom_range(0, 3) == 0 ? 59 : $urandom_range(0, 59),
                       $urandom_range(0, 3) == 0 ? 59 : $urandom_range(0, 59),
                       $urandom_range(0, 3) == 0 ? 23 : $urandom_range(0, 23), 1, 1, 0);
         end
         t.in_month = 4'($urandom_range(1, 12));
         t.in_day   = 5'($urandom_range(0, 2) == 0 ? $urandom_range(28, 31)
                                                   : $urandom_range(1, 28));
         t.in_year  = 14'($urandom_range(0, 4) == 0 ? SPECIAL_YEARS[$urandom_range(0, 9)]
                                                    : $urandom_range(0, 9999));
      end
      return t;
   endfunction

   // Offer one moment, opening a new burst after a random gap
   task automatic send_moment(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 25);
         burst_left = $urandom_range(1, 60);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Hold off requests until every pending result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // Result sink: switch between open, random and sparse acceptance
   always @(posedge clock) begin
      if (sink_stretch == 0) begin
         sink_mode    <= sink_mode_type'($urandom_range(0, 2));
         sink_stretch <= $urandom_range(10, 150);
      end else begin
         sink_stretch <= sink_stretch - 1;
      end
      case (sink_mode)
         SINK_OPEN: begin
            rsp_ready <= 1'b1;
         end
         SINK_RANDOM: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Plain ticks and each carry up the chain
      send_moment(moment(0, 0, 0, 1, 1, 0));
      send_moment(moment(15, 30, 12, 15, 6, 2023));
      send_moment(moment(59, 0, 0, 1, 1, 2023));
      send_moment(moment(59, 59, 0, 1, 1, 2023));
      send_moment(moment(59, 59, 22, 10, 3, 2023));
      send_moment(moment(59, 59, 23, 10, 3, 2023));
      send_moment(moment(59, 59, 23, 31, 1, 2023));
      // February in common, leap and century years, year zero
      send_moment(moment(59, 59, 23, 28, 2, 2023));
      send_moment(moment(59, 59, 23, 28, 2, 2024));
      send_moment(moment(59, 59, 23, 29, 2, 2024));
      send_moment(moment(59, 59, 23, 28, 2, 1900));
      send_moment(moment(0, 0, 0, 29, 2, 1900));
      send_moment(moment(59, 59, 23, 29, 2, 2000));
      send_moment(moment(59, 59, 23, 29, 2, 0));
      // Month ends, year end and the wrap after the last year
      send_moment(moment(59, 59, 23, 30, 4, 2023));
      send_moment(moment(0, 0, 0, 31, 4, 2023));
      send_moment(moment(59, 59, 23, 31, 12, 2023));
      send_moment(moment(59, 59, 23, 31, 12, 9999));
      // Out-of-range fields, all ones included
      send_moment(moment(60, 0, 0, 1, 1, 2023));
      send_moment(moment(63, 63, 31, 31, 15, 16383));
      send_moment(moment(0, 60, 0, 1, 1, 2023));
      send_moment(moment(0, 0, 24, 1, 1, 2023));
      send_moment(moment(0, 0, 0, 0, 1, 2023));
      send_moment(moment(0, 0, 0, 1, 0, 2023));
      send_moment(moment(0, 0, 0, 1, 13, 2023));
      send_moment(moment(0, 0, 0, 1, 1, 10000));
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            drain_results();
         end
         send_moment(random_moment());
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && waiting_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
